// ===== design/baro_pressure_temp_compensation_assert.svh =====
// assertion macros used by the barometer compensation checker
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define BPTC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define BPTC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/bptc_pkg.sv =====
// widths, constants and register codes for the barometer compensation pipeline
package bptc_pkg;

  localparam int RAW_W  = 24;
  localparam int CAL_W  = 16;
  localparam int TEMP_W = 16;
  localparam int PRES_W = 18;
  localparam int CFG_IDX_W = 3;

  localparam int NUM_STG = 11;

  localparam int C5_SHIFT        = 8;
  localparam int T_SHIFT         = 23;
  localparam int T2_SHIFT        = 31;
  localparam int OFF_SHIFT       = 7;
  localparam int SENS_SHIFT      = 8;
  localparam int OFF_BASE_SHIFT  = 16;
  localparam int SENS_BASE_SHIFT = 15;
  localparam int PROD_SHIFT      = 21;
  localparam int P_SHIFT         = 15;

  localparam int DT_W     = RAW_W + 1;
  localparam int PT_W     = DT_W + CAL_W + 1;
  localparam int DTSQ_W   = 2 * DT_W;
  localparam int DIFF_W   = PT_W - T_SHIFT;
  localparam int TMP_W    = DIFF_W + 1;
  localparam int T2_W     = 18;
  localparam int OFFSH_W  = PT_W - OFF_SHIFT;
  localparam int SENSSH_W = PT_W - SENS_SHIFT;
  localparam int OFF_W    = 40;
  localparam int SENS_W   = 39;
  localparam int SQ_W     = 36;
  localparam int CORR_W   = 40;
  localparam int LO_W     = 20;
  localparam int HI_W     = SENS_W - LO_W;
  localparam int PP_W     = RAW_W + LO_W;
  localparam int PROD_W   = 64;
  localparam int PSH_W    = PROD_W - PROD_SHIFT;
  localparam int PD_W     = PSH_W + 1;
  localparam int P_W      = PD_W - P_SHIFT;

  localparam int TEMP_REF      = 2000;
  localparam int TEMP_VLOW_OFS = 3500;
  localparam int PRES_LO       = 1000;
  localparam int PRES_HI       = 120000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS     = 3'd0,
    REG_OFF      = 3'd1,
    REG_TCS      = 3'd2,
    REG_TCO      = 3'd3,
    REG_TREF     = 3'd4,
    REG_TEMPSENS = 3'd5
  } cfg_reg_t;

endpackage

// ===== design/baro_pressure_temp_compensation.sv =====
// barometer second-order temperature compensation, pipelined top level
//
// input channel: in_valid/in_ready carry one beat of raw 24-bit pressure and
// temperature conversions. output channel: out_valid/out_ready carry one beat
// of temperature in centidegrees, pressure in pascals and a range flag.
// calibration words are written through cfg_wr_en/cfg_index/cfg_data, one
// 16-bit word per cycle. the user must write them only while the pipeline
// holds no beat; the block itself does not enforce this.
//
// one beat is accepted every cycle unless a held output has backed up every
// stage. the depth is set by the chain of multiplies: raw products, correction
// squares, then the 24 by 39 bit pressure product split into two partial
// products that are summed and shifted before the offset is subtracted.
// synchronous reset clears the calibration words and every stage valid bit.
// when the receiver holds out_ready low the output beat stays put and the
// stages behind it keep filling until every stage holds a beat; only then
// does in_ready drop.
module baro_pressure_temp_compensation (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [bptc_pkg::RAW_W-1:0]          in_raw_pressure,
  input  logic [bptc_pkg::RAW_W-1:0]          in_raw_temperature,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [bptc_pkg::TEMP_W-1:0]  out_temperature_centi,
  output logic [bptc_pkg::PRES_W-1:0]         out_pressure_pa,
  output logic                                out_out_of_range,
  input  logic                                cfg_wr_en,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bptc_pkg::CAL_W-1:0]          cfg_data
);
  import bptc_pkg::*;

  // calibration words
  logic [CAL_W-1:0] cal_sens_r, cal_off_r, cal_tcs_r, cal_tco_r, cal_tref_r, cal_tempsens_r;

  // stage control
  logic [NUM_STG:1] vld_r, vld_nxt, stg_ld;

  // stage 1
  logic [RAW_W-1:0]        s1_d1_r;
  logic signed [DT_W-1:0]  s1_dt_r, s1_dt_nxt;
  // stage 2
  logic [RAW_W-1:0]          s2_d1_r;
  logic signed [PT_W-1:0]    s2_pt_r, s2_pt_nxt, s2_poff_r, s2_poff_nxt, s2_psens_r, s2_psens_nxt;
  logic signed [DTSQ_W-1:0]  s2_dtsq_r, s2_dtsq_nxt;
  // stage 3
  logic [RAW_W-1:0]           s3_d1_r;
  logic signed [DIFF_W-1:0]   s3_diff_r, s3_diff_nxt;
  logic signed [TMP_W-1:0]    s3_temp_r, s3_temp_nxt, s3_tp_r, s3_tp_nxt;
  logic signed [OFFSH_W-1:0]  s3_offsh;
  logic signed [SENSSH_W-1:0] s3_senssh;
  logic signed [OFF_W-1:0]    s3_off_r, s3_off_nxt;
  logic signed [SENS_W-1:0]   s3_sens_r, s3_sens_nxt;
  logic [T2_W-1:0]            s3_t2_r, s3_t2_nxt;
  // stage 4
  logic [RAW_W-1:0]            s4_d1_r;
  logic                        s4_low_r, s4_vlow_r;
  logic signed [TMP_W-1:0]     s4_temp_r, s4_temp_nxt;
  logic signed [OFF_W-1:0]     s4_off_r;
  logic signed [SENS_W-1:0]    s4_sens_r;
  logic signed [2*DIFF_W-1:0]  s4_sqa_full;
  logic signed [2*TMP_W-1:0]   s4_sqb_full;
  logic [SQ_W-1:0]             s4_sqa_r, s4_sqb_r;
  // stage 5
  logic [RAW_W-1:0]          s5_d1_r;
  logic signed [TMP_W-1:0]   s5_temp_r;
  logic signed [OFF_W-1:0]   s5_off_r;
  logic signed [SENS_W-1:0]  s5_sens_r;
  logic [CORR_W-1:0]         s5_sqa_x, s5_sqb_x;
  logic [CORR_W-1:0]         s5_five_r, s5_five_nxt, s5_seven_r, s5_seven_nxt;
  logic [CORR_W-1:0]         s5_eleven_r, s5_eleven_nxt;
  // stage 6
  logic [RAW_W-1:0]          s6_d1_r;
  logic signed [TMP_W-1:0]   s6_temp_r;
  logic signed [OFF_W-1:0]   s6_off_r;
  logic signed [SENS_W-1:0]  s6_sens_r;
  logic [CORR_W-1:0]         s6_off2_r, s6_off2_nxt, s6_sens2_r, s6_sens2_nxt;
  // stage 7
  logic [RAW_W-1:0]          s7_d1_r;
  logic signed [TMP_W-1:0]   s7_temp_r;
  logic signed [OFF_W-1:0]   s7_off_r, s7_off_nxt;
  logic signed [SENS_W-1:0]  s7_sens_r, s7_sens_nxt;
  // stage 8
  logic signed [TMP_W-1:0]   s8_temp_r;
  logic signed [OFF_W-1:0]   s8_off_r;
  logic [PP_W-1:0]           s8_pplo_r, s8_pplo_nxt;
  logic signed [PP_W-1:0]    s8_pphi_r, s8_pphi_nxt;
  // stage 9
  logic signed [TMP_W-1:0]   s9_temp_r;
  logic signed [OFF_W-1:0]   s9_off_r;
  logic signed [PROD_W-1:0]  s9_prod;
  logic signed [PSH_W-1:0]   s9_psh_r, s9_psh_nxt;
  // stage 10
  logic signed [TMP_W-1:0]   s10_temp_r;
  logic signed [PD_W-1:0]    s10_pd;
  logic signed [P_W-1:0]     s10_p_r, s10_p_nxt;
  // stage 11 (output)
  logic signed [TEMP_W-1:0]  out_temp_r, out_temp_nxt;
  logic [PRES_W-1:0]         out_pres_r, out_pres_nxt;
  logic                      out_oor_r, out_oor_nxt;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_sens_r     <= '0;
      cal_off_r      <= '0;
      cal_tcs_r      <= '0;
      cal_tco_r      <= '0;
      cal_tref_r     <= '0;
      cal_tempsens_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SENS:     cal_sens_r     <= cfg_data;
        REG_OFF:      cal_off_r      <= cfg_data;
        REG_TCS:      cal_tcs_r      <= cfg_data;
        REG_TCO:      cal_tco_r      <= cfg_data;
        REG_TREF:     cal_tref_r     <= cfg_data;
        REG_TEMPSENS: cal_tempsens_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage loads when it is empty or its beat moves on
  always_comb begin
    stg_ld[NUM_STG] = !vld_r[NUM_STG] || out_ready;
    for (int k = NUM_STG - 1; k >= 1; k--) begin
      stg_ld[k] = !vld_r[k] || stg_ld[k+1];
    end
    vld_nxt = vld_r;
    if (stg_ld[1]) vld_nxt[1] = in_valid;
    for (int k = 2; k <= NUM_STG; k++) begin
      if (stg_ld[k]) vld_nxt[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // datapath
  assign s1_dt_nxt = $signed({1'b0, in_raw_temperature})
                   - $signed({1'b0, cal_tref_r, {C5_SHIFT{1'b0}}});

  assign s2_pt_nxt    = s1_dt_r * $signed({1'b0, cal_tempsens_r});
  assign s2_poff_nxt  = s1_dt_r * $signed({1'b0, cal_tco_r});
  assign s2_psens_nxt = s1_dt_r * $signed({1'b0, cal_tcs_r});
  assign s2_dtsq_nxt  = s1_dt_r * s1_dt_r;

  // floor shifts are plain part-selects of the signed products
  assign s3_diff_nxt = s2_pt_r[PT_W-1:T_SHIFT];
  assign s3_temp_nxt = TMP_W'(s3_diff_nxt) + TMP_W'(TEMP_REF);
  assign s3_tp_nxt   = TMP_W'(s3_diff_nxt) + TMP_W'(TEMP_VLOW_OFS);
  assign s3_offsh    = s2_poff_r[PT_W-1:OFF_SHIFT];
  assign s3_senssh   = s2_psens_r[PT_W-1:SENS_SHIFT];
  assign s3_off_nxt  = {{(OFF_W-OFFSH_W){s3_offsh[OFFSH_W-1]}}, s3_offsh}
                     + {{(OFF_W-CAL_W-OFF_BASE_SHIFT){1'b0}}, cal_off_r,
                        {OFF_BASE_SHIFT{1'b0}}};
  assign s3_sens_nxt = {{(SENS_W-SENSSH_W){s3_senssh[SENSSH_W-1]}}, s3_senssh}
                     + {{(SENS_W-CAL_W-SENS_BASE_SHIFT){1'b0}}, cal_sens_r,
                        {SENS_BASE_SHIFT{1'b0}}};
  assign s3_t2_nxt   = s2_dtsq_r[T2_SHIFT+T2_W-1:T2_SHIFT];

  // low-temperature tests use the temperature before the t2 term
  assign s4_temp_nxt = s3_diff_r[DIFF_W-1] ? (s3_temp_r - TMP_W'(s3_t2_r)) : s3_temp_r;
  assign s4_sqa_full = s3_diff_r * s3_diff_r;
  assign s4_sqb_full = s3_tp_r * s3_tp_r;

  assign s5_sqa_x      = CORR_W'(s4_sqa_r);
  assign s5_sqb_x      = CORR_W'(s4_sqb_r);
  assign s5_five_nxt   = s4_low_r ? ((s5_sqa_x << 2) + s5_sqa_x) : '0;
  assign s5_seven_nxt  = s4_vlow_r ? ((s5_sqb_x << 3) - s5_sqb_x) : '0;
  assign s5_eleven_nxt = s4_vlow_r ? ((s5_sqb_x << 3) + (s5_sqb_x << 1) + s5_sqb_x) : '0;

  assign s6_off2_nxt  = (s5_five_r >> 1) + s5_seven_r;
  assign s6_sens2_nxt = (s5_five_r >> 2) + (s5_eleven_r >> 1);

  assign s7_off_nxt  = s6_off_r - $signed(s6_off2_r);
  assign s7_sens_nxt = s6_sens_r - $signed(s6_sens2_r[SENS_W-1:0]);

  // pressure product split at bit LO_W of the sensitivity
  assign s8_pplo_nxt = s7_d1_r * s7_sens_r[LO_W-1:0];
  assign s8_pphi_nxt = $signed({1'b0, s7_d1_r}) * $signed(s7_sens_r[SENS_W-1:LO_W]);

  assign s9_prod    = ({{(PROD_W-PP_W){s8_pphi_r[PP_W-1]}}, s8_pphi_r} <<< LO_W)
                    + $signed({{(PROD_W-PP_W){1'b0}}, s8_pplo_r});
  assign s9_psh_nxt = s9_prod[PROD_W-1:PROD_SHIFT];

  assign s10_pd    = {{(PD_W-PSH_W){s9_psh_r[PSH_W-1]}}, s9_psh_r}
                   - {{(PD_W-OFF_W){s9_off_r[OFF_W-1]}}, s9_off_r};
  assign s10_p_nxt = s10_pd[PD_W-1:P_SHIFT];

  // saturation and range flag
  always_comb begin
    if ((&s10_temp_r[TMP_W-1:TEMP_W-1]) || !(|s10_temp_r[TMP_W-1:TEMP_W-1])) begin
      out_temp_nxt = s10_temp_r[TEMP_W-1:0];
    end else if (s10_temp_r[TMP_W-1]) begin
      out_temp_nxt = {1'b1, {(TEMP_W-1){1'b0}}};
    end else begin
      out_temp_nxt = {1'b0, {(TEMP_W-1){1'b1}}};
    end
    priority if (s10_p_r[P_W-1]) begin
      out_pres_nxt = '0;
    end else if (|s10_p_r[P_W-2:PRES_W]) begin
      out_pres_nxt = '1;
    end else begin
      out_pres_nxt = s10_p_r[PRES_W-1:0];
    end
    out_oor_nxt = (s10_p_r < P_W'(PRES_LO)) || (s10_p_r > P_W'(PRES_HI));
  end

  always_ff @(posedge clk) begin
    if (stg_ld[1]) begin
      s1_d1_r <= in_raw_pressure;
      s1_dt_r <= s1_dt_nxt;
    end
    if (stg_ld[2]) begin
      s2_d1_r    <= s1_d1_r;
      s2_pt_r    <= s2_pt_nxt;
      s2_poff_r  <= s2_poff_nxt;
      s2_psens_r <= s2_psens_nxt;
      s2_dtsq_r  <= s2_dtsq_nxt;
    end
    if (stg_ld[3]) begin
      s3_d1_r   <= s2_d1_r;
      s3_diff_r <= s3_diff_nxt;
      s3_temp_r <= s3_temp_nxt;
      s3_tp_r   <= s3_tp_nxt;
      s3_off_r  <= s3_off_nxt;
      s3_sens_r <= s3_sens_nxt;
      s3_t2_r   <= s3_t2_nxt;
    end
    if (stg_ld[4]) begin
      s4_d1_r   <= s3_d1_r;
      s4_low_r  <= s3_diff_r[DIFF_W-1];
      s4_vlow_r <= s3_tp_r[TMP_W-1];
      s4_temp_r <= s4_temp_nxt;
      s4_off_r  <= s3_off_r;
      s4_sens_r <= s3_sens_r;
      s4_sqa_r  <= s4_sqa_full[SQ_W-1:0];
      s4_sqb_r  <= s4_sqb_full[SQ_W-1:0];
    end
    if (stg_ld[5]) begin
      s5_d1_r     <= s4_d1_r;
      s5_temp_r   <= s4_temp_r;
      s5_off_r    <= s4_off_r;
      s5_sens_r   <= s4_sens_r;
      s5_five_r   <= s5_five_nxt;
      s5_seven_r  <= s5_seven_nxt;
      s5_eleven_r <= s5_eleven_nxt;
    end
    if (stg_ld[6]) begin
      s6_d1_r    <= s5_d1_r;
      s6_temp_r  <= s5_temp_r;
      s6_off_r   <= s5_off_r;
      s6_sens_r  <= s5_sens_r;
      s6_off2_r  <= s6_off2_nxt;
      s6_sens2_r <= s6_sens2_nxt;
    end
    if (stg_ld[7]) begin
      s7_d1_r   <= s6_d1_r;
      s7_temp_r <= s6_temp_r;
      s7_off_r  <= s7_off_nxt;
      s7_sens_r <= s7_sens_nxt;
    end
    if (stg_ld[8]) begin
      s8_temp_r <= s7_temp_r;
      s8_off_r  <= s7_off_r;
      s8_pplo_r <= s8_pplo_nxt;
      s8_pphi_r <= s8_pphi_nxt;
    end
    if (stg_ld[9]) begin
      s9_temp_r <= s8_temp_r;
      s9_off_r  <= s8_off_r;
      s9_psh_r  <= s9_psh_nxt;
    end
    if (stg_ld[10]) begin
      s10_temp_r <= s9_temp_r;
      s10_p_r    <= s10_p_nxt;
    end
    if (stg_ld[11]) begin
      out_temp_r <= out_temp_nxt;
      out_pres_r <= out_pres_nxt;
      out_oor_r  <= out_oor_nxt;
    end
  end

  assign in_ready              = stg_ld[1];
  assign out_valid             = vld_r[NUM_STG];
  assign out_temperature_centi = out_temp_r;
  assign out_pressure_pa       = out_pres_r;
  assign out_out_of_range      = out_oor_r;

endmodule

// ===== design/bptc_checker.sv =====
// port-level checker for the barometer compensation block, with its bind
`include "baro_pressure_temp_compensation_assert.svh"

module bptc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [bptc_pkg::TEMP_W-1:0]  out_temperature_centi,
  input logic [bptc_pkg::PRES_W-1:0]         out_pressure_pa,
  input logic                                out_out_of_range
);
  import bptc_pkg::*;

  logic [TEMP_W+PRES_W:0] out_bus;
  logic                   out_in_band;

  assign out_bus     = {out_temperature_centi, out_pressure_pa, out_out_of_range};
  assign out_in_band = (out_pressure_pa >= PRES_W'(PRES_LO))
                    && (out_pressure_pa <= PRES_W'(PRES_HI));

  // a stalled output beat holds
  `BPTC_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_bus), "stalled beat changed")

  // an in-range flag means the saturated pressure lies inside the band
  `BPTC_ASSERT_IMP(a_range_flag, out_valid && !out_out_of_range, out_in_band, "range flag disagrees")

  // an empty output stage lets every stage load, so input is open
  `BPTC_ASSERT_IMP(a_ready_open, !out_valid, in_ready, "input blocked with empty output stage")

  // no beat is offered straight out of reset
  `BPTC_ASSERT_IMP(a_reset_empty, $rose(rst_n), !out_valid, "output valid right after reset")

endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (.*);
